// ===== src/gdad_pkg.sv =====
// Shared types, constants, microcode program and calendar functions for the date adder.
`default_nettype none

package gdad_pkg;

    // Input and result beats
    typedef struct packed {
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [15:0] days_to_add;
    } t_gdad_in;

    typedef struct packed {
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [13:0] result_year;
        logic        overflow;
    } t_gdad_out;

    // Datapath widths
    localparam int unsigned PC_W   = 3;
    localparam int unsigned TOT_W  = 17;
    localparam int unsigned YEAR_W = 15;
    localparam int unsigned REM_W  = 14;
    localparam int unsigned K_W    = 3;

    // Calendar constants
    localparam logic [YEAR_W-1:0] YEAR_LIMIT    = 15'd9999;
    localparam logic [REM_W-1:0]  CYCLE_400     = 14'd400;
    localparam logic [REM_W-1:0]  CYCLE_400_END = 14'd399;
    localparam logic [REM_W-1:0]  CENTURY_1     = 14'd100;
    localparam logic [REM_W-1:0]  CENTURY_2     = 14'd200;
    localparam logic [REM_W-1:0]  CENTURY_3     = 14'd300;
    localparam logic [8:0]        DAYS_LEAP     = 9'd366;
    localparam logic [8:0]        DAYS_PLAIN    = 9'd365;
    localparam logic [4:0]        FEB_LEAP      = 5'd29;
    localparam logic [4:0]        FEB_PLAIN     = 5'd28;
    localparam logic [4:0]        SHORT_MONTH   = 5'd30;
    localparam logic [4:0]        LONG_MONTH    = 5'd31;
    localparam logic [3:0]        JANUARY       = 4'd1;
    localparam logic [3:0]        FEBRUARY      = 4'd2;
    localparam logic [3:0]        APRIL         = 4'd4;
    localparam logic [3:0]        JUNE          = 4'd6;
    localparam logic [3:0]        SEPTEMBER     = 4'd9;
    localparam logic [3:0]        NOVEMBER      = 4'd11;
    localparam logic [3:0]        DECEMBER      = 4'd12;
    localparam logic [K_W-1:0]    K_TOP         = 3'd5;   // 400 << 5 still fits 14 bits

    // Micro-operations and jump conditions
    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_LOAD       = 3'd1,
        OP_MOD_STEP   = 3'd2,
        OP_SUM_MONTH  = 3'd3,
        OP_YEAR       = 3'd4,
        OP_MONTH_INIT = 3'd5,
        OP_MONTH      = 3'd6,
        OP_EMIT       = 3'd7
    } t_gdad_op;

    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_ALWAYS     = 3'd1,
        C_NO_INPUT   = 3'd2,
        C_K_MORE     = 3'd3,
        C_SUM_MORE   = 3'd4,
        C_YEAR_MORE  = 3'd5,
        C_MONTH_MORE = 3'd6,
        C_OUT_BUSY   = 3'd7
    } t_gdad_cond;

    typedef struct packed {
        t_gdad_op          op;
        t_gdad_cond        cond;
        logic [PC_W-1:0]   target;
    } t_gdad_cw;

    typedef struct packed {
        logic k_more;
        logic sum_more;
        logic year_more;
        logic month_more;
    } t_gdad_dp_flags;

    typedef struct packed {
        logic           in_valid;
        logic           out_busy;
        t_gdad_dp_flags dp;
    } t_gdad_flags;

    // Program addresses
    localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] PC_MOD   = 3'd1;
    localparam logic [PC_W-1:0] PC_SUM   = 3'd2;
    localparam logic [PC_W-1:0] PC_YEAR  = 3'd3;
    localparam logic [PC_W-1:0] PC_MINIT = 3'd4;
    localparam logic [PC_W-1:0] PC_MONTH = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT  = 3'd6;
    localparam logic [PC_W-1:0] PC_WRAP  = 3'd7;

    // Microcode: jump to target when the condition holds, else step on
    function automatic t_gdad_cw gdad_ucode(input logic [PC_W-1:0] pc);
        t_gdad_cw cw;
        case (pc)
            PC_IDLE:  cw = '{op: OP_LOAD,       cond: C_NO_INPUT,   target: PC_IDLE};
            PC_MOD:   cw = '{op: OP_MOD_STEP,   cond: C_K_MORE,     target: PC_MOD};
            PC_SUM:   cw = '{op: OP_SUM_MONTH,  cond: C_SUM_MORE,   target: PC_SUM};
            PC_YEAR:  cw = '{op: OP_YEAR,       cond: C_YEAR_MORE,  target: PC_YEAR};
            PC_MINIT: cw = '{op: OP_MONTH_INIT, cond: C_NEVER,      target: PC_IDLE};
            PC_MONTH: cw = '{op: OP_MONTH,      cond: C_MONTH_MORE, target: PC_MONTH};
            PC_EMIT:  cw = '{op: OP_EMIT,       cond: C_OUT_BUSY,   target: PC_EMIT};
            PC_WRAP:  cw = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_IDLE};
            default:  cw = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_IDLE};
        endcase
        return cw;
    endfunction

    // Leap test on the year modulo 400
    function automatic logic gdad_leap(input logic [REM_W-1:0] rem);
        return (rem == '0) ||
               ((rem[1:0] == 2'b00) && (rem != CENTURY_1) &&
                (rem != CENTURY_2) && (rem != CENTURY_3));
    endfunction

    function automatic logic [4:0] gdad_mlen(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == FEBRUARY) begin
            len = leap ? FEB_LEAP : FEB_PLAIN;
        end else if (month inside {APRIL, JUNE, SEPTEMBER, NOVEMBER}) begin
            len = SHORT_MONTH;
        end else begin
            len = LONG_MONTH;
        end
        return len;
    endfunction

    function automatic logic [8:0] gdad_ylen(input logic leap);
        return leap ? DAYS_LEAP : DAYS_PLAIN;
    endfunction

endpackage

`default_nettype wire

// ===== src/gdad_seq.sv =====
// Microcode sequencer: step counter, program table lookup and conditional jumps.
`default_nettype none

module gdad_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gdad_pkg::t_gdad_flags i_flags,
    output gdad_pkg::t_gdad_cw        o_cw
);
    import gdad_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_gdad_cw        cw;
    logic            take;

    always_comb begin
        cw = gdad_ucode(r_pc);
        case (cw.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_INPUT:   take = !i_flags.in_valid;
            C_K_MORE:     take = i_flags.dp.k_more;
            C_SUM_MORE:   take = i_flags.dp.sum_more;
            C_YEAR_MORE:  take = i_flags.dp.year_more;
            C_MONTH_MORE: take = i_flags.dp.month_more;
            C_OUT_BUSY:   take = i_flags.out_busy;
            default:      take = 1'b0;
        endcase
        n_pc = take ? cw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_cw = cw;

endmodule

`default_nettype wire

// ===== src/gdad_dp.sv =====
// Date datapath: operand registers, adders/subtractors and the calendar lookups.
`default_nettype none

module gdad_dp (
    input  wire logic                  i_clk,
    input  wire gdad_pkg::t_gdad_op    i_op,
    input  wire logic                  i_load,
    input  wire gdad_pkg::t_gdad_in    i_in,
    output gdad_pkg::t_gdad_dp_flags   o_flags,
    output gdad_pkg::t_gdad_out        o_result
);
    import gdad_pkg::*;

    logic [3:0]        r_m;
    logic [YEAR_W-1:0] r_y;
    logic [REM_W-1:0]  r_rem;
    logic [K_W-1:0]    r_k;
    logic [TOT_W-1:0]  r_tot;
    logic [3:0]        r_mi;

    logic [4:0]        day_in;
    logic [3:0]        month_in;
    logic [13:0]       year_in;
    logic              leap;
    logic [4:0]        cur_mlen;
    logic [8:0]        cur_ylen;
    logic [REM_W-1:0]  sub400;
    logic              overflow;

    always_comb begin
        day_in   = (i_in.start_day == '0) ? 5'd1 : i_in.start_day;
        month_in = (i_in.start_month == '0)      ? JANUARY  :
                   (i_in.start_month > DECEMBER) ? DECEMBER : i_in.start_month;
        year_in  = (i_in.start_year == '0) ? 14'd1 : i_in.start_year;

        leap     = gdad_leap(r_rem);
        cur_mlen = gdad_mlen(r_mi, leap);
        cur_ylen = gdad_ylen(leap);
        sub400   = CYCLE_400 << r_k;

        o_flags.k_more     = (r_k != '0);
        o_flags.sum_more   = ({1'b0, r_mi} + 5'd1) < {1'b0, r_m};
        o_flags.year_more  = r_tot > TOT_W'(cur_ylen);
        o_flags.month_more = (r_mi < DECEMBER) && (r_tot > TOT_W'(cur_mlen));

        overflow = r_y > YEAR_LIMIT;
        o_result.overflow     = overflow;
        o_result.result_day   = overflow ? LONG_MONTH : r_tot[4:0];
        o_result.result_month = overflow ? DECEMBER : r_mi;
        o_result.result_year  = overflow ? YEAR_LIMIT[13:0] : r_y[13:0];
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (i_load) begin
                    r_m   <= month_in;
                    r_y   <= {1'b0, year_in};
                    r_rem <= year_in;
                    r_k   <= K_TOP;
                    r_mi  <= JANUARY;
                    r_tot <= TOT_W'(day_in) + TOT_W'(i_in.days_to_add);
                end
            end
            OP_MOD_STEP: begin
                // restoring reduction of the year modulo 400
                if (r_rem >= sub400) begin
                    r_rem <= r_rem - sub400;
                end
                r_k <= r_k - 1'b1;
            end
            OP_SUM_MONTH: begin
                if (r_mi < r_m) begin
                    r_tot <= r_tot + TOT_W'(cur_mlen);
                    r_mi  <= r_mi + 1'b1;
                end
            end
            OP_YEAR: begin
                if (o_flags.year_more) begin
                    r_tot <= r_tot - TOT_W'(cur_ylen);
                    r_y   <= r_y + 1'b1;
                    r_rem <= (r_rem == CYCLE_400_END) ? '0 : r_rem + 1'b1;
                end
            end
            OP_MONTH_INIT: begin
                r_mi <= JANUARY;
            end
            OP_MONTH: begin
                if (o_flags.month_more) begin
                    r_tot <= r_tot - TOT_W'(cur_mlen);
                    r_mi  <= r_mi + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/gregorian_date_add_days.sv =====
// Top level of the Gregorian date adder: sequencer, datapath and output register.
// Program: load, reduce the year modulo 400, add the months before the start month,
// consume whole years, restart at January, consume whole months, then emit.
// Throughput: one item at a time; the next input beat is taken after the wrap step
// that follows the result load; emit waits while the sink stalls a result.
// Reset: synchronous, active low; program to idle, output emptied, datapath not reset.
`default_nettype none

module gregorian_date_add_days (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gdad_pkg::t_gdad_in i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gdad_pkg::t_gdad_out     o_out_data
);
    import gdad_pkg::*;

    t_gdad_cw       cw;
    t_gdad_flags    flags;
    t_gdad_dp_flags dp_flags;
    t_gdad_out      dp_result;

    logic      in_fire;
    logic      out_busy;
    logic      emit;

    logic      r_out_valid;
    t_gdad_out r_out;

    // Take an input beat only on the idle step of the program
    assign o_in_stall = (cw.op != OP_LOAD);
    assign in_fire    = i_in_valid && (cw.op == OP_LOAD);

    // The output register is busy while it holds a beat the sink is stalling
    assign out_busy = r_out_valid && i_out_stall;
    assign emit     = (cw.op == OP_EMIT) && !out_busy;

    always_comb begin
        flags.in_valid = i_in_valid;
        flags.out_busy = out_busy;
        flags.dp       = dp_flags;
    end

    gdad_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_cw    (cw)
    );

    gdad_dp u_dp (
        .i_clk    (i_clk),
        .i_op     (cw.op),
        .i_load   (in_fire),
        .i_in     (i_in_data),
        .o_flags  (dp_flags),
        .o_result (dp_result)
    );

    // Hold the result beat until the sink takes it; drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= dp_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== src/gdad_checker.sv =====
// Port-level checker for the date adder, bound to the top level.
`default_nettype none

module gdad_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire gdad_pkg::t_gdad_in  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire gdad_pkg::t_gdad_out o_out_data
);
    import gdad_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // Busy after taking an input beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    // Overflow clamps the date to the last day of the limit year
    a_overflow_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |->
            (o_out_data.result_day == LONG_MONTH) &&
            (o_out_data.result_month == DECEMBER) &&
            (o_out_data.result_year == YEAR_LIMIT[13:0]))
        else $error("overflow result not clamped");

    // A normal result is a plausible date
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.overflow |->
            (o_out_data.result_month >= JANUARY) &&
            (o_out_data.result_month <= DECEMBER) &&
            (o_out_data.result_day != '0) &&
            (o_out_data.result_year != '0))
        else $error("result date out of range");

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (.*);

`default_nettype wire
